// ===== src/crt_pkg.sv =====
// Shared types, constants and tables for the cube mesh rotate/translate block.
// Used by every module of the block; depends on nothing.
`default_nettype none

package crt_pkg;

  localparam int SINE_DEPTH_DEF = 1024;

  localparam int VERTEX_COUNT = 36;
  localparam int VTX_W        = 6;
  localparam int TRIG_SLOTS   = 6;
  localparam int SLOT_W       = 3;
  localparam int DRAIN_CYCLES = 3;

  localparam int TURN_W  = 16;
  localparam int SIZE_W  = 31;
  localparam int SCALE_W = 30;
  localparam int OUT_W   = 32;
  localparam int COORD_W = 34;
  localparam int TRIG_W  = 17;
  localparam int SUM_W   = 52;
  localparam int ROUND_SHIFT = 15;

  localparam logic [SIZE_W-1:0] ROOT_TWELFTH_Q32 = 31'd1239850262;
  localparam logic [TURN_W-1:0] QUARTER_TURN     = 16'h4000;
  localparam longint unsigned   HALF_PI_Q30      = 64'd1686629713;
  localparam longint unsigned   TAYLOR_DIV [7]   = '{6, 20, 42, 72, 110, 156, 210};

  // bit 2: x positive, bit 1: y positive, bit 0: z positive
  localparam logic [2:0] SIGN_ROM [VERTEX_COUNT] = '{
    3'd0, 3'd4, 3'd2, 3'd4, 3'd2, 3'd6, 3'd2, 3'd6, 3'd3, 3'd3, 3'd6, 3'd7,
    3'd4, 3'd6, 3'd7, 3'd7, 3'd4, 3'd5, 3'd1, 3'd5, 3'd3, 3'd5, 3'd3, 3'd7,
    3'd0, 3'd4, 3'd1, 3'd1, 3'd4, 3'd5, 3'd0, 3'd2, 3'd3, 3'd3, 3'd0, 3'd1
  };

  typedef enum logic [SLOT_W-1:0] {
    SLOT_COS_X = 3'd0,
    SLOT_SIN_X = 3'd1,
    SLOT_COS_Y = 3'd2,
    SLOT_SIN_Y = 3'd3,
    SLOT_COS_Z = 3'd4,
    SLOT_SIN_Z = 3'd5
  } crt_slot_t;

  typedef struct packed {
    logic signed [OUT_W-1:0]  center_x;
    logic signed [OUT_W-1:0]  center_y;
    logic signed [OUT_W-1:0]  center_z;
    logic        [SIZE_W-1:0] size_h;
    logic        [TURN_W-1:0] turn_about_x;
    logic        [TURN_W-1:0] turn_about_y;
    logic        [TURN_W-1:0] turn_about_z;
  } crt_in_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] vertex_x;
    logic signed [OUT_W-1:0] vertex_y;
    logic signed [OUT_W-1:0] vertex_z;
    logic        [VTX_W-1:0] vertex_number;
    logic                    last_vertex;
  } crt_out_t;

  typedef struct packed {
    logic             load;
    logic             trig_issue;
    crt_slot_t        trig_slot;
    logic             vtx_issue;
    logic [VTX_W-1:0] vtx_num;
  } crt_cmd_t;

endpackage

`default_nettype wire

// ===== src/crt_sine_rom.sv =====
// Quarter-wave sine table, Q1.15 magnitudes, built at elaboration, registered read.
// Depends on crt_pkg.
`default_nettype none

module crt_sine_rom #(
  parameter int SINE_TABLE_DEPTH = crt_pkg::SINE_DEPTH_DEF
) (
  input  wire logic                                    clk,
  input  wire logic [$clog2(SINE_TABLE_DEPTH+1)-1:0]   rd_addr,
  output logic      [15:0]                             rd_data
);
  import crt_pkg::*;

  typedef logic [15:0] rom_t [SINE_TABLE_DEPTH+1];

  function automatic rom_t build_rom();
    rom_t              rom;
    longint unsigned   x;
    longint unsigned   x2;
    longint unsigned   term;
    longint            acc;
    longint unsigned   e;
    int                k;
    for (int i = 0; i <= SINE_TABLE_DEPTH; i++) begin
      x    = (HALF_PI_Q30 * longint'(i)) / SINE_TABLE_DEPTH;
      x2   = (x * x) >> 30;
      term = x;
      acc  = longint'(x);
      for (k = 1; k <= 7; k++) begin
        term = (term * x2) >> 30;
        term = term / TAYLOR_DIV[k-1];
        if (k % 2 == 1) begin
          acc = acc - longint'(term);
        end else begin
          acc = acc + longint'(term);
        end
      end
      if (acc < 0) begin
        acc = 0;
      end
      e = (longint'(acc) + 64'd16384) >> 15;
      if (e > 64'd32768) begin
        e = 64'd32768;
      end
      rom[i] = e[15:0];
    end
    return rom;
  endfunction

  localparam rom_t SINE_ROM = build_rom();

  logic [15:0] rd_data_r;

  always_ff @(posedge clk) begin
    rd_data_r <= SINE_ROM[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// ===== src/crt_ctrl.sv =====
// Sequencer: trig lookups, one vertex issue per cycle, pipeline drain.
// Depends on crt_pkg; drives crt_datapath through crt_cmd_t.
`default_nettype none

module crt_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  output crt_pkg::crt_cmd_t      cmd
);
  import crt_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_TRIG  = 4'b0010,
    S_RUN   = 4'b0100,
    S_DRAIN = 4'b1000
  } crt_state_t;

  crt_state_t       state_r, state_nxt;
  logic [VTX_W-1:0] cnt_r, cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    cmd           = '0;
    cmd.trig_slot = crt_slot_t'(cnt_r[SLOT_W-1:0]);
    cmd.vtx_num   = cnt_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_TRIG;
          cnt_nxt   = '0;
        end
      end
      S_TRIG: begin
        cmd.trig_issue = (cnt_r < VTX_W'(TRIG_SLOTS));
        if (cnt_r == VTX_W'(TRIG_SLOTS)) begin
          state_nxt = S_RUN;
          cnt_nxt   = '0;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_RUN: begin
        cmd.vtx_issue = 1'b1;
        if (cnt_r == VTX_W'(VERTEX_COUNT - 1)) begin
          state_nxt = S_DRAIN;
          cnt_nxt   = '0;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_DRAIN: begin
        if (cnt_r == VTX_W'(DRAIN_CYCLES - 1)) begin
          state_nxt = S_IDLE;
          cnt_nxt   = '0;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
        cnt_nxt   = '0;
      end
    endcase
  end

  assign busy = (state_r != S_IDLE);

endmodule

`default_nettype wire

// ===== src/crt_datapath.sv =====
// Held request, sine lookup, scale, three rotation stages and translate/saturate.
// Depends on crt_pkg and crt_sine_rom; commanded by crt_ctrl.
`default_nettype none

module crt_datapath #(
  parameter int SINE_TABLE_DEPTH = crt_pkg::SINE_DEPTH_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  crt_pkg::crt_cmd_t      cmd,
  input  crt_pkg::crt_in_t       in_data,
  output logic                   out_valid,
  output crt_pkg::crt_out_t      out_data
);
  import crt_pkg::*;

  localparam int IDX_W  = $clog2(SINE_TABLE_DEPTH + 1);
  localparam int FRAC_W = 14;
  localparam logic signed [SUM_W-1:0] ROUND_BIAS = 52'sd16384;
  localparam logic signed [OUT_W-1:0] SAT_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [OUT_W-1:0] SAT_MIN = 32'sh8000_0000;

  function automatic logic signed [COORD_W-1:0] mac_round(
    input logic signed [TRIG_W-1:0]  c,
    input logic signed [TRIG_W-1:0]  s,
    input logic signed [COORD_W-1:0] u,
    input logic signed [COORD_W-1:0] v
  );
    logic signed [SUM_W-1:0] acc;
    acc = SUM_W'(c) * SUM_W'(u) + SUM_W'(s) * SUM_W'(v) + ROUND_BIAS;
    return COORD_W'(acc >>> ROUND_SHIFT);
  endfunction

  function automatic logic signed [OUT_W-1:0] sat_add(
    input logic signed [COORD_W-1:0] v,
    input logic signed [OUT_W-1:0]   c
  );
    logic signed [COORD_W:0] s;
    s = (COORD_W+1)'(v) + (COORD_W+1)'(c);
    if (s[COORD_W:OUT_W-1] == '0 || s[COORD_W:OUT_W-1] == '1) begin
      return s[OUT_W-1:0];
    end else if (s[COORD_W]) begin
      return SAT_MIN;
    end else begin
      return SAT_MAX;
    end
  endfunction

  crt_in_t in_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      in_r <= in_data;
    end
  end

  // scale a = round(h * sqrt(1/12))
  logic [2*SIZE_W-1:0] scale_sum;
  logic [SCALE_W-1:0]  a_r;

  assign scale_sum = (2*SIZE_W)'(in_r.size_h) * (2*SIZE_W)'(ROOT_TWELFTH_Q32)
                   + (2*SIZE_W)'(64'h8000_0000);

  always_ff @(posedge clk) begin
    a_r <= scale_sum[2*SIZE_W-1:32];
  end

  // sine lookup
  logic [TURN_W-1:0]        turn_sel;
  logic [TURN_W-1:0]        angle;
  logic [FRAC_W+IDX_W-1:0]  frac_scaled;
  logic [IDX_W-1:0]         r_idx;
  logic [IDX_W-1:0]         rom_addr;
  logic [15:0]              rom_data;
  logic                     is_cos;

  always_comb begin
    case (cmd.trig_slot)
      SLOT_COS_X, SLOT_SIN_X: turn_sel = in_r.turn_about_x;
      SLOT_COS_Y, SLOT_SIN_Y: turn_sel = in_r.turn_about_y;
      default:                turn_sel = in_r.turn_about_z;
    endcase
    is_cos = (cmd.trig_slot == SLOT_COS_X) || (cmd.trig_slot == SLOT_COS_Y) ||
             (cmd.trig_slot == SLOT_COS_Z);
    angle       = is_cos ? turn_sel + QUARTER_TURN : turn_sel;
    frac_scaled = (FRAC_W+IDX_W)'(angle[FRAC_W-1:0]) * (FRAC_W+IDX_W)'(SINE_TABLE_DEPTH);
    r_idx       = frac_scaled[FRAC_W+IDX_W-1:FRAC_W];
    rom_addr    = angle[FRAC_W] ? IDX_W'(SINE_TABLE_DEPTH) - r_idx : r_idx;
  end

  crt_sine_rom #(
    .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
  ) u_rom (
    .clk     (clk),
    .rd_addr (rom_addr),
    .rd_data (rom_data)
  );

  logic                    rd_valid_r;
  crt_slot_t               rd_slot_r;
  logic                    rd_neg_r;
  logic signed [TRIG_W-1:0] rom_mag;
  logic signed [TRIG_W-1:0] trig_r [TRIG_SLOTS];

  assign rom_mag = $signed({1'b0, rom_data});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_valid_r <= 1'b0;
    end else begin
      rd_valid_r <= cmd.trig_issue;
    end
  end

  always_ff @(posedge clk) begin
    rd_slot_r <= cmd.trig_slot;
    rd_neg_r  <= angle[FRAC_W+1];
    if (rd_valid_r) begin
      trig_r[rd_slot_r] <= rd_neg_r ? -rom_mag : rom_mag;
    end
  end

  // rotation pipeline
  logic [2:0]                sg;
  logic signed [COORD_W-1:0] a_pos, a_neg;
  logic signed [COORD_W-1:0] x0, y0, z0;

  assign sg    = SIGN_ROM[cmd.vtx_num];
  assign a_pos = $signed({{(COORD_W-SCALE_W){1'b0}}, a_r});
  assign a_neg = -a_pos;
  assign x0    = sg[2] ? a_pos : a_neg;
  assign y0    = sg[1] ? a_pos : a_neg;
  assign z0    = sg[0] ? a_pos : a_neg;

  logic                      v1_r, v2_r, v3_r, out_valid_r;
  logic [VTX_W-1:0]          n1_r, n2_r, n3_r;
  logic signed [COORD_W-1:0] x1_r, y1_r, z1_r;
  logic signed [COORD_W-1:0] x2_r, y2_r, z2_r;
  logic signed [COORD_W-1:0] x3_r, y3_r, z3_r;
  crt_out_t                  out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      v1_r        <= cmd.vtx_issue;
      v2_r        <= v1_r;
      v3_r        <= v2_r;
      out_valid_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    n1_r <= cmd.vtx_num;
    x1_r <= x0;
    y1_r <= mac_round(trig_r[SLOT_COS_X], trig_r[SLOT_SIN_X], y0, z0);
    z1_r <= mac_round(trig_r[SLOT_COS_X], -trig_r[SLOT_SIN_X], z0, y0);

    n2_r <= n1_r;
    x2_r <= mac_round(trig_r[SLOT_COS_Y], trig_r[SLOT_SIN_Y], x1_r, z1_r);
    y2_r <= y1_r;
    z2_r <= mac_round(trig_r[SLOT_COS_Y], -trig_r[SLOT_SIN_Y], z1_r, x1_r);

    n3_r <= n2_r;
    x3_r <= mac_round(trig_r[SLOT_COS_Z], trig_r[SLOT_SIN_Z], x2_r, y2_r);
    y3_r <= mac_round(trig_r[SLOT_COS_Z], -trig_r[SLOT_SIN_Z], y2_r, x2_r);
    z3_r <= z2_r;

    out_r.vertex_x      <= sat_add(x3_r, in_r.center_x);
    out_r.vertex_y      <= sat_add(y3_r, in_r.center_y);
    out_r.vertex_z      <= sat_add(z3_r, in_r.center_z);
    out_r.vertex_number <= n3_r;
    out_r.last_vertex   <= (n3_r == VTX_W'(VERTEX_COUNT - 1));
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire

// ===== src/cube_mesh_rotate_translate.sv =====
// Top level of the cube mesh rotate/translate block.
// Depends on crt_pkg, crt_ctrl and crt_datapath.
//
// Usage:
//   A request word (center, size h, three turn angles) is taken on in_data at
//   a clock edge where start is high and busy is low. The block then emits the
//   36 vertices of the cube's 12 triangles, one word per cycle on out_data,
//   each marked by out_valid for exactly one cycle, in vertex order 0 to 35;
//   last_vertex flags vertex 35.
//   Sequence: the six sine lookups go first, through the table's single read
//   port; vertices then issue on consecutive cycles into a four-stage pipeline
//   (rotate x, rotate y, rotate z, translate and saturate). No new request is
//   taken during a run; busy drops in the cycle that shows vertex 35, so the
//   next request can be taken at the end of that cycle.
//   The receiver cannot stall: every out_valid word must be taken when shown.
//   Reset (rst_n low, synchronous) returns the sequencer to idle and clears
//   all strobes; a run in progress is dropped.
`default_nettype none

module cube_mesh_rotate_translate #(
  parameter int SINE_TABLE_DEPTH = crt_pkg::SINE_DEPTH_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  crt_pkg::crt_in_t       in_data,
  output logic                   out_valid,
  output crt_pkg::crt_out_t      out_data
);
  import crt_pkg::*;

  crt_cmd_t cmd;

  crt_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .cmd   (cmd)
  );

  crt_datapath #(
    .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

// ===== src/crt_checker.sv =====
// Port-level checks of the vertex run, bound to cube_mesh_rotate_translate.
// Depends on crt_pkg.
`default_nettype none

module crt_checker (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              start,
  input wire logic              busy,
  input wire logic              out_valid,
  input crt_pkg::crt_out_t      out_data
);
  import crt_pkg::*;

  ap_run_continuous: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.last_vertex |=> out_valid)
    else $error("vertex run broken before last word");

  ap_run_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.last_vertex |=> !out_valid)
    else $error("word follows last vertex");

  ap_number_steps: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.last_vertex |=>
      out_data.vertex_number == $past(out_data.vertex_number) + 6'd1)
    else $error("vertex number does not advance by one");

  ap_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("request taken but busy low");

  ap_busy_during_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.last_vertex |-> busy)
    else $error("vertex word shown while idle");

endmodule

bind cube_mesh_rotate_translate crt_checker u_crt_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_data  (out_data)
);

`default_nettype wire
